[rtl/local_mean_binarizer_3x3_top_assert.svh]
// Assertion macros shared by the binarizer RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef LOCAL_MEAN_BINARIZER_3X3_TOP_ASSERT_SVH
`define LOCAL_MEAN_BINARIZER_3X3_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define LMB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset.
`define LMB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[rtl/lmb_pkg.sv]
// Package for the 3x3 local mean binarizer: widths, register map, result kinds
// and the command/status structs between controller and datapath. No dependencies.
package lmb_pkg;

  localparam int PIX_W      = 8;   // gray pixel
  localparam int CFG_W      = 12;  // frame_width / frame_height registers
  localparam int POS_W      = 11;  // out_row / out_col
  localparam int SUM_W      = 12;  // up to 9 * 255
  localparam int CNT_W      = 4;   // up to 9 neighbors
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd1200;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd734;

  // register index = paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // result kinds, also their bit positions in the pending mask (emit order)
  localparam int RES_ABOVE_LEFT = 0;  // (r-1, c-1)
  localparam int RES_ABOVE      = 1;  // (r-1, c) at row end
  localparam int RES_LEFT       = 2;  // (r, c-1) on last row
  localparam int RES_HERE       = 3;  // (r, c) last row, row end
  localparam int NUM_RES        = 4;

  typedef struct packed {
    logic capture;  // take input item, start line store read
    logic advance;  // shift window, write line store, step position
    logic emit;     // load next pending result into output register
  } lmb_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic pend_any;  // results of the current item remain
    logic pend_one;  // exactly one remains
  } lmb_status_t;

endpackage

[rtl/local_mean_binarizer_3x3_top.sv]
// Top level of the 3x3 local mean binarizer.
// Depends on lmb_pkg, lmb_cfg_regs, lmb_ctrl and lmb_datapath.
//
// Usage:
//  - Input stream (s_axis): one 8-bit gray pixel per item, raster order, frames
//    of frame_width x frame_height (APB registers at 0x0 and 0x4, written only
//    while the block is idle; values below 2 act as 2, above the maximum as it).
//  - Output stream (m_axis): binarized pixels with their row and column. An
//    input item yields 0 to 4 results; tlast marks the last result of an item,
//    tuser the last result of the frame. Results lag one row and one pixel.
//  - Timing: one item at a time. An item passes the line store read at
//    capture and the update in ST_READ; in ST_EMIT it hands out one result
//    per cycle while the receiver is ready, or returns to idle if it has none.
//    Each result is registered in the output register when it is emitted.
//  - The line store is a single-port-per-cycle memory read at the current
//    column; its read latency and the one-result-per-cycle output set the rate.
//  - Reset clears positions, window and output valid; the line store is not
//    cleared and needs no clearing pass. Registers return to 1200 x 734.
//  - A stalled receiver holds the result in the output register; the block
//    keeps the next input item waiting until its results can be delivered.
module local_mean_binarizer_3x3_top import lmb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  // input pixels
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] gray_pixel
  // binarized pixels
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [10:0] out_row, [21:11] out_col,
                                                // [22] is_white, [23] zero
  output logic                  m_axis_tlast,   // last_of_run
  output logic                  m_axis_tuser    // [0] frame_end
);

  logic [CFG_W-1:0] frame_width, frame_height;
  lmb_cmd_t         cmd;
  lmb_status_t      status;
  logic [POS_W-1:0] out_row, out_col;
  logic             is_white;

  lmb_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .frame_width_o  (frame_width),
    .frame_height_o (frame_height)
  );

  lmb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  lmb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width),
    .frame_height_i (frame_height),
    .pixel_i        (s_axis_tdata[PIX_W-1:0]),
    .cmd_i          (cmd),
    .status_o       (status),
    .m_ready_i      (m_axis_tready),
    .m_valid_o      (m_axis_tvalid),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .is_white_o     (is_white),
    .last_of_run_o  (m_axis_tlast),
    .frame_end_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, is_white, out_col, out_row};

endmodule

[rtl/lmb_cfg_regs.sv]
// APB register file for frame_width and frame_height.
// Depends on lmb_pkg.
module lmb_cfg_regs import lmb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CFG_W-1:0]   frame_width_o,
  output logic [CFG_W-1:0]   frame_height_o
);

  logic [CFG_W-1:0] width_q, height_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = PDATA_W'(width_q);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(height_q);
      default:          prdata = '0;
    endcase
  end

  assign frame_width_o  = width_q;
  assign frame_height_o = height_q;

endmodule

[rtl/lmb_ctrl.sv]
// Controller FSM: accept one item, run the line store read/update, then hand
// out its results one by one. Depends on lmb_pkg and the assertion header.
`include "local_mean_binarizer_3x3_top_assert.svh"

module lmb_ctrl import lmb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  lmb_status_t status_i,
  output lmb_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.advance = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.pend_any) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.pend_one) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  `LMB_ASSERT(a_capture_then_read, clk_i, rst_ni, cmd_o.capture |=> state_q == ST_READ, "capture not followed by read")
  `LMB_ASSERT(a_emit_has_pending, clk_i, rst_ni, cmd_o.emit |-> status_i.pend_any, "emit with nothing pending")

endmodule

[rtl/lmb_datapath.sv]
// Datapath: line store memory, 3x3 window, position counters, neighborhood
// threshold and output register. Depends on lmb_pkg and the assertion header.
`include "local_mean_binarizer_3x3_top_assert.svh"

module lmb_datapath import lmb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] frame_width_i,
  input  logic [CFG_W-1:0] frame_height_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  lmb_cmd_t         cmd_i,
  output lmb_status_t      status_o,
  input  logic             m_ready_i,
  output logic             m_valid_o,
  output logic [POS_W-1:0] out_row_o,
  output logic [POS_W-1:0] out_col_o,
  output logic             is_white_o,
  output logic             last_of_run_o,
  output logic             frame_end_o
);

  localparam int CW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XWW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int XWH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  // ---- clamped limits (last column / last row index)
  logic [XWW-1:0] cfg_w;
  logic [XWH-1:0] cfg_h;
  logic [CW-1:0]  wm1;
  logic [RW-1:0]  hm1;

  always_comb begin
    cfg_w = XWW'(frame_width_i);
    cfg_h = XWH'(frame_height_i);
    if (cfg_w < XWW'(2))              wm1 = CW'(1);
    else if (cfg_w > XWW'(MAX_WIDTH)) wm1 = CW'(MAX_WIDTH - 1);
    else                              wm1 = CW'(cfg_w - XWW'(1));
    if (cfg_h < XWH'(2))               hm1 = RW'(1);
    else if (cfg_h > XWH'(MAX_HEIGHT)) hm1 = RW'(MAX_HEIGHT - 1);
    else                               hm1 = RW'(cfg_h - XWH'(1));
  end

  // ---- position counters and captured item
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [CW-1:0]    item_col_q;
  logic [RW-1:0]    item_row_q;
  logic [PIX_W-1:0] pix_q;
  logic             row_end, last_row;

  assign row_end  = item_col_q >= wm1;
  assign last_row = item_row_q >= hm1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q      <= pixel_i;
      item_col_q <= col_q;
      item_row_q <= row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.advance) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // ---- line store: {older, newer} per column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) rd_q <= line_mem[col_q];
    if (cmd_i.advance) line_mem[item_col_q] <= {rd_q[PIX_W-1:0], pix_q};
  end

  // ---- 3x3 window, column 2 is the newest
  logic [PIX_W-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.advance) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= rd_q[2*PIX_W-1:PIX_W];
      win_q[1][2] <= rd_q[PIX_W-1:0];
      win_q[2][2] <= pix_q;
    end
  end

  // ---- pending results of the current item
  logic [NUM_RES-1:0] pend_q, pend_d, pend_low, pend_rest;
  logic               r_ge1_q, r_ge2_q, c_ge2_q;

  always_comb begin
    pend_d                 = '0;
    pend_d[RES_ABOVE_LEFT] = (item_row_q != '0) && (item_col_q != '0);
    pend_d[RES_ABOVE]      = (item_row_q != '0) && row_end;
    pend_d[RES_LEFT]       = last_row && (item_col_q != '0);
    pend_d[RES_HERE]       = last_row && row_end;
  end

  assign pend_low  = pend_q & (~pend_q + NUM_RES'(1));
  assign pend_rest = pend_q & ~pend_low;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            pend_q <= '0;
    else if (cmd_i.advance) pend_q <= pend_d;
    else if (cmd_i.emit)    pend_q <= pend_rest;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      r_ge1_q <= item_row_q >= RW'(1);
      r_ge2_q <= item_row_q >= RW'(2);
      c_ge2_q <= item_col_q >= CW'(2);
    end
  end

  // ---- threshold for the selected result
  // kind bit 1: centre on the current row; kind bit 0: centre in newest column
  logic [1:0]       kind;
  logic [1:0]       cr, cc;
  logic [2:0]       rmask, cmask;
  logic [PIX_W-1:0] centre;
  logic [SUM_W-1:0] sum, prod;
  logic [CNT_W-1:0] cnt;
  logic             white;

  always_comb begin
    kind  = {pend_low[RES_HERE] | pend_low[RES_LEFT],
             pend_low[RES_HERE] | pend_low[RES_ABOVE]};
    cr    = kind[1] ? 2'd2 : 2'd1;
    cc    = kind[0] ? 2'd2 : 2'd1;
    // rows outside the frame drop out at the top/bottom, columns at the left/right
    rmask = kind[1] ? (r_ge1_q ? 3'b110 : 3'b100) : (r_ge2_q ? 3'b111 : 3'b110);
    cmask = kind[0] ? 3'b110 : (c_ge2_q ? 3'b111 : 3'b110);
    sum   = '0;
    cnt   = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rmask[i] && cmask[j]) begin
          sum = sum + SUM_W'(win_q[i][j]);
          cnt = cnt + CNT_W'(1);
        end
      end
    end
    centre = win_q[cr][cc];
    prod   = SUM_W'(SUM_W'(centre) * SUM_W'(cnt));
    white  = prod > sum;
  end

  // ---- output register
  logic             m_valid_q;
  logic [POS_W-1:0] m_row_q, m_col_q;
  logic             m_white_q, m_last_q, m_frame_end_q;
  logic [RW-1:0]    res_row;
  logic [CW-1:0]    res_col;

  assign res_row = kind[1] ? item_row_q : item_row_q - RW'(1);
  assign res_col = kind[0] ? item_col_q : item_col_q - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)         m_valid_q <= 1'b0;
    else if (cmd_i.emit) m_valid_q <= 1'b1;
    else if (m_ready_i)  m_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_row_q       <= POS_W'(res_row);
      m_col_q       <= POS_W'(res_col);
      m_white_q     <= white;
      m_last_q      <= (pend_rest == '0);
      m_frame_end_q <= pend_low[RES_HERE];
    end
  end

  assign status_o.out_free = !m_valid_q || m_ready_i;
  assign status_o.pend_any = (pend_q != '0);
  assign status_o.pend_one = (pend_q != '0) && (pend_rest == '0);

  assign m_valid_o     = m_valid_q;
  assign out_row_o     = m_row_q;
  assign out_col_o     = m_col_q;
  assign is_white_o    = m_white_q;
  assign last_of_run_o = m_last_q;
  assign frame_end_o   = m_frame_end_q;

  `LMB_ASSERT(a_emit_room, clk_i, rst_ni, cmd_i.emit |-> (!m_valid_q || m_ready_i), "result loaded over an unsent one")
  `LMB_ASSERT(a_frame_end_last, clk_i, rst_ni, m_valid_q && m_frame_end_q |-> m_last_q, "frame end not last of run")
  `LMB_ASSERT_NEVER(a_here_without_left, clk_i, rst_ni, cmd_i.advance && pend_d[RES_HERE] && !pend_d[RES_LEFT], "corner result without left neighbor")

endmodule

[test/lmb_checker.sv]
// Result checker for the 3x3 local mean binarizer: follows the register writes
// and the pixel stream, predicts each binarized pixel, compares the output stream.
// Depends on lmb_pkg.
`timescale 1ns / 1ps

module lmb_checker import lmb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_sel_i,
  input  logic                  cfg_enable_i,
  input  logic                  cfg_write_i,
  input  logic [PADDR_W-1:0]    cfg_addr_i,
  input  logic [PDATA_W-1:0]    cfg_wdata_i,
  input  logic                  cfg_ready_i,
  input  logic                  pix_valid_i,
  input  logic                  pix_ready_i,
  input  logic [IN_DATA_W-1:0]  pix_data_i,    // [7:0] gray_pixel
  input  logic                  bin_valid_i,
  input  logic                  bin_ready_i,
  input  logic [OUT_DATA_W-1:0] bin_data_i,    // [10:0] out_row, [21:11] out_col,
                                               // [22] is_white, [23] zero
  input  logic                  bin_last_i,    // last_of_run
  input  logic                  bin_user_i,    // [0] frame_end
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int LINE_DEPTH = 2048;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             white;
    logic             run_last;
    logic             frame_end;
  } bin_pixel_t;

  bin_pixel_t       bin_expect_q[$];
  logic [PIX_W-1:0] older_ln [0:LINE_DEPTH-1];
  logic [PIX_W-1:0] newer_ln [0:LINE_DEPTH-1];
  logic [PIX_W-1:0] win [0:2][0:2];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      row_pos;
  int unsigned      col_pos;
  int               mismatches;

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > LINE_DEPTH) return LINE_DEPTH;
    return v;
  endfunction

  // centre * count > sum over the window rows/columns enabled in the masks
  function automatic logic decide(int cr, int cc, logic [2:0] rmask, logic [2:0] cmask);
    int unsigned sum;
    int unsigned cnt;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (rmask[i] && cmask[j]) begin
          sum += win[i][j];
          cnt++;
        end
    return (win[cr][cc] * cnt) > sum;
  endfunction

  task automatic push_pixel(input int unsigned row, input int unsigned col,
                            input logic white, input logic fend);
    bin_pixel_t e;
    e.row       = row[POS_W-1:0];
    e.col       = col[POS_W-1:0];
    e.white     = white;
    e.run_last  = 1'b0;
    e.frame_end = fend;
    bin_expect_q.push_back(e);
  endtask

  task automatic clear_model();
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    row_pos    = 0;
    col_pos    = 0;
    mismatches = 0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      older_ln[i] = '0;
      newer_ln[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    bin_expect_q.delete();
  endtask

  task automatic predict_pixel(input logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int          n0;
    logic        row_end;
    logic        last_row;
    logic [2:0]  col3;
    logic [2:0]  upper;
    logic [2:0]  lower;
    w        = eff_dim(width_reg);
    h        = eff_dim(height_reg);
    r        = row_pos;
    c        = col_pos;
    row_end  = (c >= w - 1);
    last_row = (r >= h - 1);
    col3     = (c >= 2) ? 3'b111 : 3'b110;
    upper    = (r >= 2) ? 3'b111 : 3'b110;
    lower    = (r >= 1) ? 3'b110 : 3'b100;

    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2]   = older_ln[c];
    win[1][2]   = newer_ln[c];
    win[2][2]   = px;
    older_ln[c] = newer_ln[c];
    newer_ln[c] = px;

    n0 = bin_expect_q.size();
    if (r >= 1 && c >= 1) push_pixel(r - 1, c - 1, decide(1, 1, upper, col3), 1'b0);
    if (r >= 1 && row_end) push_pixel(r - 1, c, decide(1, 2, upper, 3'b110), 1'b0);
    if (last_row && c >= 1) push_pixel(r, c - 1, decide(2, 1, lower, col3), 1'b0);
    if (last_row && row_end) push_pixel(r, c, decide(2, 2, lower, 3'b110), 1'b1);
    if (bin_expect_q.size() > n0) bin_expect_q[bin_expect_q.size()-1].run_last = 1'b1;

    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_pixel();
    bin_pixel_t e;
    if (bin_expect_q.size() == 0) begin
      $error("unexpected result: out_row %0d out_col %0d",
             bin_data_i[POS_W-1:0], bin_data_i[2*POS_W-1:POS_W]);
      mismatches++;
    end else begin
      e = bin_expect_q.pop_front();
      if (bin_data_i[POS_W-1:0] !== e.row) begin
        $error("out_row: expected %0d, got %0d", e.row, bin_data_i[POS_W-1:0]);
        mismatches++;
      end
      if (bin_data_i[2*POS_W-1:POS_W] !== e.col) begin
        $error("out_col: expected %0d, got %0d", e.col, bin_data_i[2*POS_W-1:POS_W]);
        mismatches++;
      end
      if (bin_data_i[2*POS_W] !== e.white) begin
        $error("is_white: expected %0d, got %0d", e.white, bin_data_i[2*POS_W]);
        mismatches++;
      end
      if (bin_last_i !== e.run_last) begin
        $error("last_of_run: expected %0d, got %0d", e.run_last, bin_last_i);
        mismatches++;
      end
      if (bin_user_i !== e.frame_end) begin
        $error("frame_end: expected %0d, got %0d", e.frame_end, bin_user_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_sel_i && cfg_enable_i && cfg_write_i && cfg_ready_i) begin
        if (cfg_addr_i[2] == REG_FRAME_WIDTH) width_reg = cfg_wdata_i[CFG_W-1:0];
        else height_reg = cfg_wdata_i[CFG_W-1:0];
      end
      if (pix_valid_i && pix_ready_i) predict_pixel(pix_data_i[PIX_W-1:0]);
      if (bin_valid_i && bin_ready_i) check_pixel();
      pending_o    <= bin_expect_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[test/tb.sv]
// Top of the binarizer testbench: clock, reset, APB writes, pixel frames and
// output back-pressure; lmb_checker does the prediction. Depends on lmb_pkg,
// lmb_checker and local_mean_binarizer_3x3_top.
`timescale 1ns / 1ps

module tb;
  import lmb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 12;  // covers the read/update and result steps of an item

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [PADDR_W-1:0]    paddr         = '0;
  logic [PDATA_W-1:0]    pwdata        = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;

  local_mean_binarizer_3x3_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  lmb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_sel_i    (psel),
    .cfg_enable_i (penable),
    .cfg_write_i  (pwrite),
    .cfg_addr_i   (paddr),
    .cfg_wdata_i  (pwdata),
    .cfg_ready_i  (pready),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_i  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .bin_valid_i  (m_axis_tvalid),
    .bin_ready_i  (m_axis_tready),
    .bin_data_i   (m_axis_tdata),
    .bin_last_i   (m_axis_tlast),
    .bin_user_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // tvalid stays high across back-to-back items; dropped only for a gap
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (idle_on && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop the stream, let every expected pixel out, then let the block go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {{(PDATA_W-CFG_W){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] gen_pixel(int mode, int base);
    int v;
    case (mode)
      0: v = $urandom_range(255);
      1: v = base + $urandom_range(6) - 3;   // low contrast around a level
      2: v = base;                           // flat: never strictly above mean
      default: v = $urandom_range(1) ? 255 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  task automatic run_frame(input logic [CFG_W-1:0] wreg, input logic [CFG_W-1:0] hreg,
                           input int mode, input bit pause_mid, output int sent);
    int wd;
    int ht;
    int base;
    settle();
    write_reg(REG_FRAME_WIDTH, wreg);
    write_reg(REG_FRAME_HEIGHT, hreg);
    wd   = (wreg < 2) ? 2 : ((wreg > 2048) ? 2048 : wreg);
    ht   = (hreg < 2) ? 2 : ((hreg > 2048) ? 2048 : hreg);
    base = $urandom_range(255);
    sent = wd * ht;
    for (int i = 0; i < sent; i++) begin
      if (pause_mid && i == sent / 2) settle();
      send_pixel(gen_pixel(mode, base));
    end
  endtask

  initial begin
    logic [PIX_W-1:0] first_px [0:5];
    logic [PIX_W-1:0] tile_px  [0:8];
    int sent;
    int rand_sent;
    bit first;
    first_px = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd127};
    // corners, edges and centre each see a different neighbor count
    tile_px  = '{8'd200, 8'd10, 8'd200, 8'd10, 8'd100, 8'd10, 8'd200, 8'd10, 8'd200};
    rand_sent = 0;
    first     = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // part of row 0 at the reset size, then shrink mid-frame below the minimum
    foreach (first_px[i]) send_pixel(first_px[i]);
    settle();
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd128);
    // a whole 2x2 frame, four results on its last pixel
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd0);
    settle();
    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    foreach (tile_px[i]) send_pixel(tile_px[i]);

    // height above the maximum, then cut short mid-frame so row 3 is the last
    settle();
    write_reg(REG_FRAME_WIDTH, 12'd4);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    repeat (12) send_pixel(PIX_W'($urandom_range(255)));
    settle();
    write_reg(REG_FRAME_HEIGHT, 12'd2);
    repeat (4) send_pixel(PIX_W'($urandom_range(255)));

    // no idling on either side for a whole frame
    idle_on = 1'b0;
    run_frame(12'd10, 12'd3, 0, 1'b0, sent);
    idle_on = 1'b1;

    while (rand_sent < 62) begin
      run_frame(CFG_W'($urandom_range(9)), CFG_W'($urandom_range(5)), $urandom_range(3),
                first, sent);
      first     = 1'b0;
      rand_sent += sent;
    end

    settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
